[rtl/rc_pkg.sv]
package rc_pkg;

	localparam int VALUE_W    = 63;
	localparam int VALUE_BITS = 63;
	localparam int MAX_DIGITS = 64;

	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;
	localparam int RADIX_W = 6;
	localparam int ADDR_W  = $clog2(MAX_DIGITS);
	localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
	localparam int STEP_W  = $clog2(VALUE_BITS);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef logic [PADDR_W-3:0] reg_idx_t;
	localparam reg_idx_t REG_RADIX = reg_idx_t'(0);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

	localparam logic [DIGIT_W-1:0] DIGIT_MAX   = DIGIT_W'(35);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  ASCII_ALPHA = CHAR_W'(55); // 'A' - 10

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_RD,
		ST_OUT
	} rc_state_t;

	typedef struct packed {
		logic load;  // take a new dividend, clear remainder
		logic next;  // divide the held quotient again
	} rc_div_ctrl_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] c;
		c = (d > DIGIT_MAX) ? DIGIT_MAX : d;
		glyph = (c < DIGIT_TEN) ? ASCII_ZERO + CHAR_W'(c) : ASCII_ALPHA + CHAR_W'(c);
	endfunction

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) begin
			clamp_radix = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			clamp_radix = RADIX_MAX;
		end else begin
			clamp_radix = r;
		end
	endfunction

endpackage

[rtl/rc_value_if.sv]
interface rc_value_if;
	logic                         valid;
	logic                         ready;
	logic [rc_pkg::VALUE_W-1:0]   value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

[rtl/rc_digit_if.sv]
interface rc_digit_if;
	logic                        valid;
	logic                        ready;
	logic [rc_pkg::CHAR_W-1:0]   digit_char;
	logic                        last;

	modport source(output valid, output digit_char, output last, input ready);
	modport sink(input valid, input digit_char, input last, output ready);
endinterface

[rtl/radix_converter.sv]
// Radix converter: turns an unsigned integer into ASCII digits of the base
// held in the radix register (byte address 0, 6 bits, reset 10; values
// below 2 act as 2, above 36 as 36).
// item channel: one request carries value. It is taken only while the block
// is idle; a request sits until the previous conversion has been read out
// of the digit store (the last character may still wait in the output).
// digit channel: one character per request, most significant first, '0'-'9'
// then 'A'-'Z'; last marks the least significant digit. Zero gives '0'.
// Each digit costs one full bit-serial division of VALUE_BITS bits by the
// shared one-bit-per-cycle divider. A value of D digits takes D divisions,
// then each character is read back through ST_RD and ST_OUT; the worst
// case is base 2, 63 digits.
// The digit character sits in an output register; when the receiver
// stalls, readout waits on it and the store keeps the remaining digits.
// Reset empties the output, returns to idle and loads radix 10.
module radix_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	rc_value_if.sink                          item,
	rc_digit_if.source                        digit,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rc_pkg::PADDR_W-1:0]        paddr,
	input  logic [rc_pkg::PDATA_W-1:0]        pwdata,
	output logic [rc_pkg::PDATA_W-1:0]        prdata,
	output logic                              pready
);
	rc_pkg::rc_state_t state_q, state_nx;

	logic [rc_pkg::RADIX_W-1:0] radix_q;
	logic [rc_pkg::RADIX_W-1:0] base_q;
	logic [rc_pkg::COUNT_W-1:0] count_q;
	logic                       out_valid_q;
	logic [rc_pkg::CHAR_W-1:0]  out_char_q;
	logic                       out_last_q;

	rc_pkg::rc_div_ctrl_t            div_ctrl;
	logic [rc_pkg::VALUE_BITS-1:0]   quotient;
	logic [rc_pkg::DIGIT_W-1:0]      remainder;
	logic                            div_done;
	logic [rc_pkg::DIGIT_W-1:0]      rd_data;

	logic            accept;
	logic            out_free;
	logic            quot_zero;
	logic            store_full;
	logic            wr_en;
	logic            rd_en;
	logic            load_out;
	rc_pkg::reg_idx_t reg_idx;

	// configuration
	assign pready  = 1'b1;
	assign reg_idx = paddr[rc_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rc_pkg::RADIX_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == rc_pkg::REG_RADIX) begin
			radix_q <= pwdata[rc_pkg::RADIX_W-1:0];
		end
	end

	assign prdata = (reg_idx == rc_pkg::REG_RADIX) ? rc_pkg::PDATA_W'(radix_q) : '0;

	// datapath parts
	rc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (item.value[rc_pkg::VALUE_BITS-1:0]),
		.base      (base_q),
		.quotient  (quotient),
		.remainder (remainder),
		.done      (div_done)
	);

	rc_digit_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[rc_pkg::ADDR_W-1:0]),
		.wr_data (remainder),
		.rd_en   (rd_en),
		.rd_addr (rc_pkg::ADDR_W'(count_q - rc_pkg::COUNT_W'(1))),
		.rd_data (rd_data)
	);

	assign out_free   = !out_valid_q || digit.ready;
	assign quot_zero  = (quotient == '0);
	assign store_full = (count_q == rc_pkg::COUNT_W'(rc_pkg::MAX_DIGITS - 1));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rc_pkg::ST_IDLE: begin
				if (item.valid) state_nx = rc_pkg::ST_DIV;
			end
			rc_pkg::ST_DIV: begin
				if (div_done) state_nx = rc_pkg::ST_STORE;
			end
			rc_pkg::ST_STORE: begin
				state_nx = (quot_zero || store_full) ? rc_pkg::ST_RD : rc_pkg::ST_DIV;
			end
			rc_pkg::ST_RD: begin
				if (out_free) state_nx = rc_pkg::ST_OUT;
			end
			rc_pkg::ST_OUT: begin
				state_nx = (count_q == '0) ? rc_pkg::ST_IDLE : rc_pkg::ST_RD;
			end
			default: state_nx = rc_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item.ready    = 1'b0;
		div_ctrl.load = 1'b0;
		div_ctrl.next = 1'b0;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			rc_pkg::ST_IDLE: begin
				item.ready    = 1'b1;
				div_ctrl.load = item.valid;
			end
			rc_pkg::ST_STORE: begin
				wr_en         = 1'b1;
				div_ctrl.next = !(quot_zero || store_full);
			end
			rc_pkg::ST_RD: begin
				rd_en = out_free;
			end
			rc_pkg::ST_OUT: begin
				load_out = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign accept = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + rc_pkg::COUNT_W'(1);
			end else if (rd_en) begin
				count_q <= count_q - rc_pkg::COUNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (digit.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= rc_pkg::clamp_radix(radix_q);
		end
		if (load_out) begin
			out_char_q <= rc_pkg::glyph(rd_data);
			out_last_q <= (count_q == '0);
		end
	end

	assign digit.valid      = out_valid_q;
	assign digit.digit_char = out_char_q;
	assign digit.last       = out_last_q;

	// checks
	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == rc_pkg::ST_DIV)
		else $error("division did not start after request");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rc_pkg::ST_OUT |=> out_valid_q)
		else $error("character not presented after readout");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rc_pkg::COUNT_W'(rc_pkg::MAX_DIGITS))
		else $error("digit count beyond store depth");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rc_pkg::ST_OUT |-> !out_valid_q)
		else $error("character register overwritten");
endmodule

[rtl/rc_divider.sv]
// Restoring divider, one quotient bit per cycle. The quotient replaces the
// dividend in place, so a following division just restarts on it.
module rc_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rc_pkg::rc_div_ctrl_t            ctrl,
	input  logic [rc_pkg::VALUE_BITS-1:0]   dividend,
	input  logic [rc_pkg::RADIX_W-1:0]      base,
	output logic [rc_pkg::VALUE_BITS-1:0]   quotient,
	output logic [rc_pkg::DIGIT_W-1:0]      remainder,
	output logic                            done
);
	logic [rc_pkg::VALUE_BITS-1:0] quot_q;
	logic [rc_pkg::DIGIT_W-1:0]    rem_q;
	logic [rc_pkg::STEP_W-1:0]     step_q;
	logic                          busy_q;

	logic [rc_pkg::DIGIT_W:0] trial;
	logic                     ge;
	logic [rc_pkg::DIGIT_W:0] diff;

	assign trial = {rem_q, quot_q[rc_pkg::VALUE_BITS-1]};
	assign ge    = trial >= (rc_pkg::DIGIT_W+1)'(base);
	assign diff  = trial - (rc_pkg::DIGIT_W+1)'(base);
	assign done  = busy_q && (step_q == rc_pkg::STEP_W'(rc_pkg::VALUE_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (ctrl.load || ctrl.next) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			step_q <= step_q + rc_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (ctrl.next) begin
			rem_q <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[rc_pkg::VALUE_BITS-2:0], ge};
			rem_q  <= ge ? diff[rc_pkg::DIGIT_W-1:0] : trial[rc_pkg::DIGIT_W-1:0];
		end
	end

	assign quotient  = quot_q;
	assign remainder = rem_q;
endmodule

[rtl/rc_digit_ram.sv]
module rc_digit_ram (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [rc_pkg::ADDR_W-1:0]      wr_addr,
	input  logic [rc_pkg::DIGIT_W-1:0]     wr_data,
	input  logic                           rd_en,
	input  logic [rc_pkg::ADDR_W-1:0]      rd_addr,
	output logic [rc_pkg::DIGIT_W-1:0]     rd_data
);
	logic [rc_pkg::DIGIT_W-1:0] mem [rc_pkg::MAX_DIGITS];
	logic [rc_pkg::DIGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule
